// ===== rtl/s5h_pkg.sv =====
// Shared types, codes and constants of the SOCKS5 server handshake block.
package s5h_pkg;

    localparam int unsigned MAX_HOST_LEN = 256;

    localparam logic [31:0] BIND_ADDRESS_RESET = 32'h7F00_0001;
    localparam logic [15:0] LISTEN_PORT_RESET  = 16'd1080;

    localparam logic [7:0] SOCKS_VERSION  = 8'h05;
    localparam logic [7:0] METHOD_NO_AUTH = 8'h00;
    localparam logic [7:0] METHOD_REJECT  = 8'hFF;
    localparam logic [7:0] CMD_CONNECT    = 8'h01;
    localparam logic [7:0] ATYP_IPV4      = 8'h01;
    localparam logic [7:0] ATYP_DOMAIN    = 8'h03;
    localparam logic [7:0] RSV_BYTE       = 8'h00;
    localparam logic [7:0] REP_SUCCEEDED  = 8'h00;
    localparam logic [7:0] REP_BAD_CMD    = 8'h07;
    localparam logic [7:0] REP_BAD_ATYP   = 8'h08;

    localparam logic [1:0] KIND_REPLY  = 2'd0;
    localparam logic [1:0] KIND_ADDR   = 2'd1;
    localparam logic [1:0] KIND_FINISH = 2'd2;

    localparam logic [2:0] OC_OK          = 3'd0;
    localparam logic [2:0] OC_BAD_GVER    = 3'd1;
    localparam logic [2:0] OC_NO_METHODS  = 3'd2;
    localparam logic [2:0] OC_NO_ACCEPT   = 3'd3;
    localparam logic [2:0] OC_BAD_RVER    = 3'd4;
    localparam logic [2:0] OC_BAD_CMD     = 3'd5;
    localparam logic [2:0] OC_BAD_ATYP    = 3'd6;
    localparam logic [2:0] OC_BAD_DOMLEN  = 3'd7;

    localparam logic [2:0] OP_ADDR   = 3'd0;
    localparam logic [2:0] OP_FINISH = 3'd1;
    localparam logic [2:0] OP_SELECT = 3'd2;
    localparam logic [2:0] OP_REJECT = 3'd3;
    localparam logic [2:0] OP_ERROR  = 3'd4;
    localparam logic [2:0] OP_OK     = 3'd5;

    localparam logic [3:0] REPLY_LEN = 4'd10;

    typedef struct packed {
        logic [2:0]  op;
        logic [7:0]  data;
        logic        addr_type;
        logic [15:0] port;
        logic [2:0]  outcome;
    } cmd_t;

    typedef struct packed {
        logic [1:0]  out_kind;
        logic [7:0]  out_byte;
        logic        addr_type;
        logic [15:0] dest_port;
        logic [2:0]  outcome;
        logic        last;
    } item_t;

endpackage

// ===== rtl/s5h_if.sv =====
// Valid/ready channel interfaces for client bytes and result items.
interface s5h_in_if;
    logic       valid;
    logic       ready;
    logic [7:0] rx_byte;

    modport source (output valid, output rx_byte, input ready);
    modport sink (input valid, input rx_byte, output ready);
endinterface

interface s5h_out_if;
    logic        valid;
    logic        ready;
    logic [1:0]  out_kind;
    logic [7:0]  out_byte;
    logic        addr_type;
    logic [15:0] dest_port;
    logic [2:0]  outcome;
    logic        last;

    modport source (output valid, output out_kind, output out_byte, output addr_type,
                    output dest_port, output outcome, output last, input ready);
    modport sink (input valid, input out_kind, input out_byte, input addr_type,
                  input dest_port, input outcome, input last, output ready);
endinterface

// ===== rtl/s5h_front.sv =====
// Front end: accepts client bytes, tracks the handshake phase and issues commands.
module s5h_front #(
    parameter int unsigned MAX_HOST_LEN = s5h_pkg::MAX_HOST_LEN
) (
    input  logic            clk,
    input  logic            rst_n,
    s5h_in_if.sink          rx,
    input  logic            q_ready,
    output logic            push,
    output s5h_pkg::cmd_t   push_cmd
);

    localparam logic [3:0] PH_GVER  = 4'd0;
    localparam logic [3:0] PH_GNM   = 4'd1;
    localparam logic [3:0] PH_METH  = 4'd2;
    localparam logic [3:0] PH_RVER  = 4'd3;
    localparam logic [3:0] PH_RCMD  = 4'd4;
    localparam logic [3:0] PH_RRSV  = 4'd5;
    localparam logic [3:0] PH_RATYP = 4'd6;
    localparam logic [3:0] PH_IPV4  = 4'd7;
    localparam logic [3:0] PH_DLEN  = 4'd8;
    localparam logic [3:0] PH_DOM   = 4'd9;
    localparam logic [3:0] PH_PHI   = 4'd10;
    localparam logic [3:0] PH_PLO   = 4'd11;

    localparam logic [8:0] HOST_LIMIT = 9'(MAX_HOST_LEN - 1);
    localparam logic [7:0] IPV4_LEN   = 8'd4;
    localparam logic [7:0] ERR_NONE   = 8'd0;
    localparam logic [7:0] ERR_RVER   = 8'({5'd0, s5h_pkg::OC_BAD_RVER});
    localparam logic [7:0] ERR_CMD    = 8'({5'd0, s5h_pkg::OC_BAD_CMD});

    logic [3:0] phase_reg, phase_next;
    logic [7:0] byte_count_reg, byte_count_next;
    logic [7:0] method_count_reg, method_count_next;
    logic       no_auth_reg, no_auth_next;
    logic       addr_kind_reg, addr_kind_next;
    logic [7:0] dom_len_reg, dom_len_next;
    logic [7:0] port_high_reg, port_high_next;

    logic       accept;
    logic       go_idle;
    logic [7:0] b;
    logic [7:0] count_inc;

    assign rx.ready  = q_ready;
    assign accept    = rx.valid && q_ready;
    assign b         = rx.rx_byte;
    assign count_inc = byte_count_reg + 8'd1;

    always_comb
    begin
        phase_next        = phase_reg;
        byte_count_next   = byte_count_reg;
        method_count_next = method_count_reg;
        no_auth_next      = no_auth_reg;
        addr_kind_next    = addr_kind_reg;
        dom_len_next      = dom_len_reg;
        port_high_next    = port_high_reg;
        go_idle           = 1'b0;
        push              = 1'b0;
        push_cmd          = '0;
        if (accept)
        begin
            case (phase_reg)
                PH_GNM:
                begin
                    if (b == 8'd0)
                    begin
                        push             = 1'b1;
                        push_cmd.op      = s5h_pkg::OP_FINISH;
                        push_cmd.outcome = s5h_pkg::OC_NO_METHODS;
                        go_idle          = 1'b1;
                    end
                    else
                    begin
                        method_count_next = b;
                        byte_count_next   = 8'd0;
                        no_auth_next      = 1'b0;
                        phase_next        = PH_METH;
                    end
                end
                PH_METH:
                begin
                    no_auth_next    = no_auth_reg || (b == s5h_pkg::METHOD_NO_AUTH);
                    byte_count_next = count_inc;
                    if (count_inc == method_count_reg)
                    begin
                        push = 1'b1;
                        if (no_auth_next)
                        begin
                            push_cmd.op       = s5h_pkg::OP_SELECT;
                            push_cmd.data     = s5h_pkg::METHOD_NO_AUTH;
                            method_count_next = ERR_NONE;
                            phase_next        = PH_RVER;
                        end
                        else
                        begin
                            push_cmd.op      = s5h_pkg::OP_REJECT;
                            push_cmd.data    = s5h_pkg::METHOD_REJECT;
                            push_cmd.outcome = s5h_pkg::OC_NO_ACCEPT;
                            go_idle          = 1'b1;
                        end
                    end
                end
                PH_RVER:
                begin
                    method_count_next = (b != s5h_pkg::SOCKS_VERSION) ? ERR_RVER : ERR_NONE;
                    phase_next        = PH_RCMD;
                end
                PH_RCMD:
                begin
                    if (method_count_reg == ERR_NONE && b != s5h_pkg::CMD_CONNECT)
                    begin
                        method_count_next = ERR_CMD;
                    end
                    phase_next = PH_RRSV;
                end
                PH_RRSV:
                begin
                    phase_next = PH_RATYP;
                end
                PH_RATYP:
                begin
                    if (method_count_reg == ERR_RVER)
                    begin
                        push             = 1'b1;
                        push_cmd.op      = s5h_pkg::OP_FINISH;
                        push_cmd.outcome = s5h_pkg::OC_BAD_RVER;
                        go_idle          = 1'b1;
                    end
                    else if (method_count_reg == ERR_CMD)
                    begin
                        push             = 1'b1;
                        push_cmd.op      = s5h_pkg::OP_ERROR;
                        push_cmd.data    = s5h_pkg::REP_BAD_CMD;
                        push_cmd.outcome = s5h_pkg::OC_BAD_CMD;
                        go_idle          = 1'b1;
                    end
                    else
                    begin
                        byte_count_next = 8'd0;
                        if (b == s5h_pkg::ATYP_IPV4)
                        begin
                            addr_kind_next = 1'b0;
                            phase_next     = PH_IPV4;
                        end
                        else if (b == s5h_pkg::ATYP_DOMAIN)
                        begin
                            addr_kind_next = 1'b1;
                            phase_next     = PH_DLEN;
                        end
                        else
                        begin
                            push             = 1'b1;
                            push_cmd.op      = s5h_pkg::OP_ERROR;
                            push_cmd.data    = s5h_pkg::REP_BAD_ATYP;
                            push_cmd.outcome = s5h_pkg::OC_BAD_ATYP;
                            go_idle          = 1'b1;
                        end
                    end
                end
                PH_IPV4:
                begin
                    push               = 1'b1;
                    push_cmd.op        = s5h_pkg::OP_ADDR;
                    push_cmd.data      = b;
                    push_cmd.addr_type = 1'b0;
                    byte_count_next    = count_inc;
                    if (count_inc >= IPV4_LEN)
                    begin
                        phase_next = PH_PHI;
                    end
                end
                PH_DLEN:
                begin
                    if (b == 8'd0 || {1'b0, b} >= HOST_LIMIT)
                    begin
                        push             = 1'b1;
                        push_cmd.op      = s5h_pkg::OP_FINISH;
                        push_cmd.outcome = s5h_pkg::OC_BAD_DOMLEN;
                        go_idle          = 1'b1;
                    end
                    else
                    begin
                        dom_len_next    = b;
                        byte_count_next = 8'd0;
                        phase_next      = PH_DOM;
                    end
                end
                PH_DOM:
                begin
                    push               = 1'b1;
                    push_cmd.op        = s5h_pkg::OP_ADDR;
                    push_cmd.data      = b;
                    push_cmd.addr_type = 1'b1;
                    byte_count_next    = count_inc;
                    if (count_inc >= dom_len_reg)
                    begin
                        phase_next = PH_PHI;
                    end
                end
                PH_PHI:
                begin
                    port_high_next = b;
                    phase_next     = PH_PLO;
                end
                PH_PLO:
                begin
                    push               = 1'b1;
                    push_cmd.op        = s5h_pkg::OP_OK;
                    push_cmd.data      = s5h_pkg::REP_SUCCEEDED;
                    push_cmd.addr_type = addr_kind_reg;
                    push_cmd.port      = {port_high_reg, b};
                    push_cmd.outcome   = s5h_pkg::OC_OK;
                    go_idle            = 1'b1;
                end
                default:
                begin
                    if (b != s5h_pkg::SOCKS_VERSION)
                    begin
                        push             = 1'b1;
                        push_cmd.op      = s5h_pkg::OP_FINISH;
                        push_cmd.outcome = s5h_pkg::OC_BAD_GVER;
                        go_idle          = 1'b1;
                    end
                    else
                    begin
                        phase_next = PH_GNM;
                    end
                end
            endcase
            if (go_idle)
            begin
                phase_next        = PH_GVER;
                byte_count_next   = 8'd0;
                method_count_next = 8'd0;
                no_auth_next      = 1'b0;
                addr_kind_next    = 1'b0;
                dom_len_next      = 8'd0;
                port_high_next    = 8'd0;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            phase_reg        <= PH_GVER;
            byte_count_reg   <= 8'd0;
            method_count_reg <= 8'd0;
            no_auth_reg      <= 1'b0;
            addr_kind_reg    <= 1'b0;
            dom_len_reg      <= 8'd0;
            port_high_reg    <= 8'd0;
        end
        else
        begin
            phase_reg        <= phase_next;
            byte_count_reg   <= byte_count_next;
            method_count_reg <= method_count_next;
            no_auth_reg      <= no_auth_next;
            addr_kind_reg    <= addr_kind_next;
            dom_len_reg      <= dom_len_next;
            port_high_reg    <= port_high_next;
        end
    end

endmodule

// ===== rtl/s5h_queue.sv =====
// Two-entry command queue between the front end and the result sequencer.
module s5h_queue (
    input  logic            clk,
    input  logic            rst_n,
    input  logic            push,
    input  s5h_pkg::cmd_t   push_cmd,
    input  logic            pop,
    output logic            full,
    output logic            empty,
    output s5h_pkg::cmd_t   head
);

    s5h_pkg::cmd_t entry_reg [2];
    logic          wr_ptr_reg, wr_ptr_next;
    logic          rd_ptr_reg, rd_ptr_next;
    logic [1:0]    count_reg, count_next;

    assign full  = (count_reg == 2'd2);
    assign empty = (count_reg == 2'd0);
    assign head  = entry_reg[rd_ptr_reg];

    always_comb
    begin
        wr_ptr_next = push ? ~wr_ptr_reg : wr_ptr_reg;
        rd_ptr_next = pop ? ~rd_ptr_reg : rd_ptr_reg;
        count_next  = count_reg + {1'b0, push} - {1'b0, pop};
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= 1'b0;
            rd_ptr_reg <= 1'b0;
            count_reg  <= 2'd0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (push)
        begin
            entry_reg[wr_ptr_reg] <= push_cmd;
        end
    end

endmodule

// ===== rtl/s5h_back.sv =====
// Back end: expands queued commands into result items, one per cycle while tx.ready is high.
module s5h_back (
    input  logic            clk,
    input  logic            rst_n,
    input  logic            head_valid,
    input  s5h_pkg::cmd_t   head,
    input  logic [31:0]     bind_address,
    input  logic [15:0]     listen_port,
    output logic            pop,
    s5h_out_if.source       tx
);

    logic                 valid_reg, valid_next;
    s5h_pkg::item_t       item_reg;
    s5h_pkg::item_t       item;
    logic [3:0]           idx_reg, idx_next;
    logic [3:0]           last_idx;
    logic                 load;
    logic [31:0]          addr_src;
    logic [15:0]          port_src;

    assign load = !valid_reg || tx.ready;
    assign pop  = load && head_valid && (idx_reg == last_idx);

    always_comb
    begin
        case (head.op)
            s5h_pkg::OP_SELECT: last_idx = 4'd1;
            s5h_pkg::OP_REJECT: last_idx = 4'd2;
            s5h_pkg::OP_ERROR:  last_idx = s5h_pkg::REPLY_LEN;
            s5h_pkg::OP_OK:     last_idx = s5h_pkg::REPLY_LEN;
            default:            last_idx = 4'd0;
        endcase
    end

    always_comb
    begin
        addr_src = (head.op == s5h_pkg::OP_OK) ? bind_address : 32'd0;
        port_src = (head.op == s5h_pkg::OP_OK) ? listen_port : 16'd0;
        item          = '0;
        item.out_kind = s5h_pkg::KIND_REPLY;
        item.last     = (idx_reg == last_idx);
        case (head.op)
            s5h_pkg::OP_ADDR:
            begin
                item.out_kind  = s5h_pkg::KIND_ADDR;
                item.out_byte  = head.data;
                item.addr_type = head.addr_type;
            end
            s5h_pkg::OP_SELECT:
            begin
                item.out_byte = (idx_reg == 4'd0) ? s5h_pkg::SOCKS_VERSION : head.data;
            end
            s5h_pkg::OP_REJECT:
            begin
                case (idx_reg)
                    4'd0:    item.out_byte = s5h_pkg::SOCKS_VERSION;
                    4'd1:    item.out_byte = head.data;
                    default: item.out_kind = s5h_pkg::KIND_FINISH;
                endcase
            end
            s5h_pkg::OP_ERROR, s5h_pkg::OP_OK:
            begin
                case (idx_reg)
                    4'd0:    item.out_byte = s5h_pkg::SOCKS_VERSION;
                    4'd1:    item.out_byte = head.data;
                    4'd2:    item.out_byte = s5h_pkg::RSV_BYTE;
                    4'd3:    item.out_byte = s5h_pkg::ATYP_IPV4;
                    4'd4:    item.out_byte = addr_src[31:24];
                    4'd5:    item.out_byte = addr_src[23:16];
                    4'd6:    item.out_byte = addr_src[15:8];
                    4'd7:    item.out_byte = addr_src[7:0];
                    4'd8:    item.out_byte = port_src[15:8];
                    4'd9:    item.out_byte = port_src[7:0];
                    default: item.out_kind = s5h_pkg::KIND_FINISH;
                endcase
            end
            default:
            begin
                item.out_kind = s5h_pkg::KIND_FINISH;
            end
        endcase
        if (item.out_kind == s5h_pkg::KIND_FINISH)
        begin
            item.out_byte  = 8'd0;
            item.addr_type = head.addr_type;
            item.dest_port = head.port;
            item.outcome   = head.outcome;
        end
    end

    always_comb
    begin
        valid_next = valid_reg;
        idx_next   = idx_reg;
        if (load)
        begin
            valid_next = head_valid;
            if (head_valid)
            begin
                idx_next = pop ? 4'd0 : idx_reg + 4'd1;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= 1'b0;
            idx_reg   <= 4'd0;
        end
        else
        begin
            valid_reg <= valid_next;
            idx_reg   <= idx_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (load && head_valid)
        begin
            item_reg <= item;
        end
    end

    assign tx.valid     = valid_reg;
    assign tx.out_kind  = item_reg.out_kind;
    assign tx.out_byte  = item_reg.out_byte;
    assign tx.addr_type = item_reg.addr_type;
    assign tx.dest_port = item_reg.dest_port;
    assign tx.outcome   = item_reg.outcome;
    assign tx.last      = item_reg.last;

endmodule

// ===== rtl/socks5_server_handshake.sv =====
// Top level of the SOCKS5 server handshake block.
//
// Client bytes enter on the rx channel, one item per byte, under valid/ready.
// Results leave on the tx channel: reply bytes for the client, target address
// bytes, and a finish item with the outcome code; the last item caused by a
// byte carries last. The cfg port writes bind_address (index 0) and
// listen_port (index 1) for the success reply; write it only while idle.
// A byte is accepted whenever the two-entry command queue has room, so bytes
// that cause at most one result flow at one per cycle while tx.ready is high.
// The first result of a byte passes the command queue and the item register
// before it appears on tx. The result sequencer emits one item per cycle
// while tx.ready is high; this output rate sets the throughput.
// Reset returns the parser to waiting for a greeting, empties the queue and
// restores the register defaults 127.0.0.1 and 1080. When the receiver holds
// tx.ready low, the current item stays on tx, the queue fills, and rx.ready
// falls once both queue entries are taken.
module socks5_server_handshake #(
    parameter int unsigned MAX_HOST_LEN = s5h_pkg::MAX_HOST_LEN
) (
    input  logic        clk,
    input  logic        rst_n,
    s5h_in_if.sink      rx,
    s5h_out_if.source   tx,
    input  logic        cfg_we,
    input  logic        cfg_index,
    input  logic [31:0] cfg_data
);

    localparam logic CFG_BIND_ADDRESS = 1'b0;
    localparam logic CFG_LISTEN_PORT  = 1'b1;

    logic [31:0]   bind_address_reg;
    logic [15:0]   listen_port_reg;
    logic          q_push;
    s5h_pkg::cmd_t q_push_cmd;
    logic          q_pop;
    logic          q_full;
    logic          q_empty;
    s5h_pkg::cmd_t q_head;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            bind_address_reg <= s5h_pkg::BIND_ADDRESS_RESET;
            listen_port_reg  <= s5h_pkg::LISTEN_PORT_RESET;
        end
        else if (cfg_we)
        begin
            case (cfg_index)
                CFG_BIND_ADDRESS: bind_address_reg <= cfg_data;
                CFG_LISTEN_PORT:  listen_port_reg  <= cfg_data[15:0];
                default:          bind_address_reg <= bind_address_reg;
            endcase
        end
    end

    s5h_front #(
        .MAX_HOST_LEN (MAX_HOST_LEN)
    ) u_front (
        .clk      (clk),
        .rst_n    (rst_n),
        .rx       (rx),
        .q_ready  (!q_full),
        .push     (q_push),
        .push_cmd (q_push_cmd)
    );

    s5h_queue u_queue (
        .clk      (clk),
        .rst_n    (rst_n),
        .push     (q_push),
        .push_cmd (q_push_cmd),
        .pop      (q_pop),
        .full     (q_full),
        .empty    (q_empty),
        .head     (q_head)
    );

    s5h_back u_back (
        .clk          (clk),
        .rst_n        (rst_n),
        .head_valid   (!q_empty),
        .head         (q_head),
        .bind_address (bind_address_reg),
        .listen_port  (listen_port_reg),
        .pop          (q_pop),
        .tx           (tx)
    );

    a_no_push_full: assert property (@(posedge clk) disable iff (!rst_n)
        q_push |-> !q_full || q_pop)
        else $error("Command pushed into a full queue.");

    a_no_pop_empty: assert property (@(posedge clk) disable iff (!rst_n)
        q_pop |-> !q_empty)
        else $error("Command popped from an empty queue.");

    a_finish_last: assert property (@(posedge clk) disable iff (!rst_n)
        tx.valid && tx.out_kind == s5h_pkg::KIND_FINISH |-> tx.last)
        else $error("Finish item is not the last item of its byte.");

    a_outcome_only_on_finish: assert property (@(posedge clk) disable iff (!rst_n)
        tx.valid && tx.out_kind != s5h_pkg::KIND_FINISH |-> tx.outcome == s5h_pkg::OC_OK)
        else $error("Outcome code set on an item that is not a finish.");

endmodule

// ===== verif/s5h_tb_pkg.sv =====
`timescale 1ns / 100ps
// Register indexes of the configuration port, shared by the testbench files.
package s5h_tb_pkg;

    localparam logic REG_BIND_ADDRESS = 1'b0;
    localparam logic REG_LISTEN_PORT  = 1'b1;

endpackage

// ===== verif/s5h_checker.sv =====
`timescale 1ns / 100ps
// Checker that follows the client bytes, works out the handshake results and compares them.
module s5h_checker
    import s5h_pkg::*;
    import s5h_tb_pkg::*;
(
    input  logic        clk,
    input  logic        rst_n,
    input  logic        rx_valid,
    input  logic        rx_ready,
    input  logic [7:0]  rx_byte,
    input  logic        tx_valid,
    input  logic        tx_ready,
    input  item_t       tx_item,
    input  logic        cfg_we,
    input  logic        cfg_index,
    input  logic [31:0] cfg_data,
    output int          fail_count,
    output int          pending_count
);

    typedef enum logic [3:0] {
        ST_GVER,
        ST_NMETH,
        ST_METH,
        ST_RVER,
        ST_RCMD,
        ST_RRSV,
        ST_RATYP,
        ST_IPV4,
        ST_DLEN,
        ST_DOM,
        ST_PHI,
        ST_PLO
    } parse_state_t;

    parse_state_t parse_state = ST_GVER;
    logic [7:0]   methods_total;
    logic [7:0]   methods_seen;
    logic         no_auth_offered;
    logic [2:0]   header_error;
    logic         domain_form;
    logic [7:0]   name_len;
    logic [7:0]   addr_seen;
    logic [7:0]   port_hi;
    logic [31:0]  reply_ip;
    logic [15:0]  bind_port;

    item_t awaited_items[$];
    item_t step_items[$];
    int    fails = 0;
    int    queued = 0;

    assign fail_count = fails;
    assign pending_count = queued;

    function automatic void emit(logic [1:0] kind, logic [7:0] data, logic at,
                                 logic [15:0] port, logic [2:0] oc);
        item_t it;
        it.out_kind = kind;
        it.out_byte = data;
        it.addr_type = at;
        it.dest_port = port;
        it.outcome = oc;
        it.last = 1'b0;
        step_items.push_back(it);
    endfunction

    function automatic void clear_parser();
        parse_state = ST_GVER;
        methods_total = 8'h00;
        methods_seen = 8'h00;
        no_auth_offered = 1'b0;
        header_error = OC_OK;
        domain_form = 1'b0;
        name_len = 8'h00;
        addr_seen = 8'h00;
        port_hi = 8'h00;
    endfunction

    function automatic void finish_handshake(logic [2:0] oc, logic at, logic [15:0] port);
        emit(KIND_FINISH, 8'h00, at, port, oc);
        clear_parser();
    endfunction

    function automatic void emit_reply(logic [7:0] code, logic [31:0] addr, logic [15:0] port);
        emit(KIND_REPLY, SOCKS_VERSION, 1'b0, 16'h0000, OC_OK);
        emit(KIND_REPLY, code, 1'b0, 16'h0000, OC_OK);
        emit(KIND_REPLY, RSV_BYTE, 1'b0, 16'h0000, OC_OK);
        emit(KIND_REPLY, ATYP_IPV4, 1'b0, 16'h0000, OC_OK);
        for (int i = 3; i >= 0; i--)
        begin
            emit(KIND_REPLY, addr[8*i +: 8], 1'b0, 16'h0000, OC_OK);
        end
        emit(KIND_REPLY, port[15:8], 1'b0, 16'h0000, OC_OK);
        emit(KIND_REPLY, port[7:0], 1'b0, 16'h0000, OC_OK);
    endfunction

    function automatic void parse_client_byte(logic [7:0] b);
        step_items.delete();
        case (parse_state)
            ST_NMETH:
            begin
                if (b == 8'h00)
                begin
                    finish_handshake(OC_NO_METHODS, 1'b0, 16'h0000);
                end
                else
                begin
                    methods_total = b;
                    methods_seen = 8'h00;
                    no_auth_offered = 1'b0;
                    parse_state = ST_METH;
                end
            end
            ST_METH:
            begin
                if (b == METHOD_NO_AUTH)
                    no_auth_offered = 1'b1;
                methods_seen = methods_seen + 8'd1;
                if (methods_seen == methods_total)
                begin
                    emit(KIND_REPLY, SOCKS_VERSION, 1'b0, 16'h0000, OC_OK);
                    if (no_auth_offered)
                    begin
                        emit(KIND_REPLY, METHOD_NO_AUTH, 1'b0, 16'h0000, OC_OK);
                        header_error = OC_OK;
                        parse_state = ST_RVER;
                    end
                    else
                    begin
                        emit(KIND_REPLY, METHOD_REJECT, 1'b0, 16'h0000, OC_OK);
                        finish_handshake(OC_NO_ACCEPT, 1'b0, 16'h0000);
                    end
                end
            end
            ST_RVER:
            begin
                header_error = (b != SOCKS_VERSION) ? OC_BAD_RVER : OC_OK;
                parse_state = ST_RCMD;
            end
            ST_RCMD:
            begin
                if (header_error == OC_OK && b != CMD_CONNECT)
                    header_error = OC_BAD_CMD;
                parse_state = ST_RRSV;
            end
            ST_RRSV:
            begin
                parse_state = ST_RATYP;
            end
            ST_RATYP:
            begin
                addr_seen = 8'h00;
                if (header_error == OC_BAD_RVER)
                begin
                    finish_handshake(OC_BAD_RVER, 1'b0, 16'h0000);
                end
                else if (header_error == OC_BAD_CMD)
                begin
                    emit_reply(REP_BAD_CMD, 32'h0, 16'h0);
                    finish_handshake(OC_BAD_CMD, 1'b0, 16'h0000);
                end
                else if (b == ATYP_IPV4)
                begin
                    domain_form = 1'b0;
                    parse_state = ST_IPV4;
                end
                else if (b == ATYP_DOMAIN)
                begin
                    domain_form = 1'b1;
                    parse_state = ST_DLEN;
                end
                else
                begin
                    emit_reply(REP_BAD_ATYP, 32'h0, 16'h0);
                    finish_handshake(OC_BAD_ATYP, 1'b0, 16'h0000);
                end
            end
            ST_IPV4:
            begin
                emit(KIND_ADDR, b, 1'b0, 16'h0000, OC_OK);
                addr_seen = addr_seen + 8'd1;
                if (addr_seen >= 8'd4)
                    parse_state = ST_PHI;
            end
            ST_DLEN:
            begin
                if (b == 8'h00 || int'(b) >= int'(MAX_HOST_LEN) - 1)
                begin
                    finish_handshake(OC_BAD_DOMLEN, 1'b0, 16'h0000);
                end
                else
                begin
                    name_len = b;
                    addr_seen = 8'h00;
                    parse_state = ST_DOM;
                end
            end
            ST_DOM:
            begin
                emit(KIND_ADDR, b, 1'b1, 16'h0000, OC_OK);
                addr_seen = addr_seen + 8'd1;
                if (addr_seen >= name_len)
                    parse_state = ST_PHI;
            end
            ST_PHI:
            begin
                port_hi = b;
                parse_state = ST_PLO;
            end
            ST_PLO:
            begin
                emit_reply(REP_SUCCEEDED, reply_ip, bind_port);
                finish_handshake(OC_OK, domain_form, {port_hi, b});
            end
            default:
            begin
                if (b != SOCKS_VERSION)
                    finish_handshake(OC_BAD_GVER, 1'b0, 16'h0000);
                else
                    parse_state = ST_NMETH;
            end
        endcase
        if (step_items.size() > 0)
            step_items[step_items.size() - 1].last = 1'b1;
        foreach (step_items[i])
            awaited_items.push_back(step_items[i]);
        step_items.delete();
    endfunction

    function automatic void compare_item(item_t got);
        item_t want;
        bit    bad;
        if (awaited_items.size() == 0)
        begin
            if (fails < 10)
                $display("unexpected result: kind %0d byte %02h type %0d port %04h %s %0d %s %0d",
                         got.out_kind, got.out_byte, got.addr_type, got.dest_port,
                         "outcome", got.outcome, "last", got.last);
            fails++;
        end
        else
        begin
            want = awaited_items.pop_front();
            bad = (got.out_kind !== want.out_kind) || (got.out_byte !== want.out_byte)
                || (got.addr_type !== want.addr_type) || (got.dest_port !== want.dest_port)
                || (got.outcome !== want.outcome) || (got.last !== want.last);
            if (bad)
            begin
                if (fails < 10)
                begin
                    $display("result mismatch: expected kind %0d byte %02h type %0d port %04h",
                             want.out_kind, want.out_byte, want.addr_type, want.dest_port);
                    $display("    expected outcome %0d last %0d",
                             want.outcome, want.last);
                    $display("    got kind %0d byte %02h type %0d port %04h",
                             got.out_kind, got.out_byte, got.addr_type, got.dest_port);
                    $display("    got outcome %0d last %0d",
                             got.outcome, got.last);
                end
                fails++;
            end
        end
    endfunction

    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            clear_parser();
            reply_ip = BIND_ADDRESS_RESET;
            bind_port = LISTEN_PORT_RESET;
            awaited_items.delete();
        end
        else
        begin
            if (cfg_we)
            begin
                if (cfg_index == REG_BIND_ADDRESS)
                    reply_ip = cfg_data;
                else if (cfg_index == REG_LISTEN_PORT)
                    bind_port = cfg_data[15:0];
            end
            if (rx_valid && rx_ready)
                parse_client_byte(rx_byte);
            if (tx_valid && tx_ready)
                compare_item(tx_item);
        end
        queued = awaited_items.size();
    end

endmodule

// ===== verif/testbench.sv =====
`timescale 1ns / 100ps
// Testbench top: clock, reset, client byte stimulus, result back-pressure and the verdict.
module testbench;
    import s5h_pkg::*;
    import s5h_tb_pkg::*;

    localparam int CYCLE_LIMIT = 300000;
    localparam int ITEMS_PER_PHASE = 15;
    localparam int DIRECTED_LEN = 26;

    typedef enum int {
        FLAW_NONE,
        FLAW_GVER,
        FLAW_NO_METHODS,
        FLAW_NO_ACCEPT,
        FLAW_RVER,
        FLAW_CMD,
        FLAW_ATYP,
        FLAW_DOMLEN,
        FLAW_NOISE
    } flaw_t;

    logic        clk;
    logic        rst_n;
    logic        cfg_we;
    logic        cfg_index;
    logic [31:0] cfg_data;
    int          fail_count;
    int          pending_count;
    int          cycles = 0;
    int          bytes_sent = 0;
    bit          src_calm = 1'b0;
    bit          sink_calm = 1'b0;
    logic [7:0]  directed_seq [DIRECTED_LEN];

    s5h_in_if  rx_ch ();
    s5h_out_if tx_ch ();

    socks5_server_handshake i_dut (
        .clk       (clk),
        .rst_n     (rst_n),
        .rx        (rx_ch),
        .tx        (tx_ch),
        .cfg_we    (cfg_we),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data)
    );

    s5h_checker i_checker (
        .clk           (clk),
        .rst_n         (rst_n),
        .rx_valid      (rx_ch.valid),
        .rx_ready      (rx_ch.ready),
        .rx_byte       (rx_ch.rx_byte),
        .tx_valid      (tx_ch.valid),
        .tx_ready      (tx_ch.ready),
        .tx_item       ({tx_ch.out_kind, tx_ch.out_byte, tx_ch.addr_type,
                         tx_ch.dest_port, tx_ch.outcome, tx_ch.last}),
        .cfg_we        (cfg_we),
        .cfg_index     (cfg_index),
        .cfg_data      (cfg_data),
        .fail_count    (fail_count),
        .pending_count (pending_count)
    );

    initial
    begin
        clk = 1'b0;
        forever #5 clk = ~clk;
    end

    always @(posedge clk)
    begin
        cycles <= cycles + 1;
        if (cycles >= CYCLE_LIMIT)
        begin
            $display("TB_ERROR");
            $finish;
        end
    end

    function automatic int draw_wait(bit calm);
        return calm ? 0 : int'($urandom_range(0, 12));
    endfunction

    function automatic logic [7:0] rand_byte();
        return 8'($urandom_range(0, 255));
    endfunction

    function automatic logic [7:0] byte_but(logic [7:0] avoid);
        logic [7:0] b;
        b = rand_byte();
        if (b == avoid)
            b = b + 8'd1;
        return b;
    endfunction

    // Called at a falling edge; returns at the falling edge after the item is taken.
    task automatic send_byte(logic [7:0] b);
        int gap;
        gap = draw_wait(src_calm);
        if (gap > 0)
        begin
            rx_ch.valid <= 1'b0;
            repeat (gap) @(negedge clk);
        end
        rx_ch.valid <= 1'b1;
        rx_ch.rx_byte <= b;
        @(posedge clk);
        while (!rx_ch.ready)
            @(posedge clk);
        bytes_sent++;
        @(negedge clk);
    endtask

    task automatic drain_results();
        rx_ch.valid <= 1'b0;
        while (pending_count != 0)
            @(negedge clk);
        repeat (8) @(negedge clk);
    endtask

    task automatic write_reg(logic idx, logic [31:0] data);
        cfg_we <= 1'b1;
        cfg_index <= idx;
        cfg_data <= data;
        @(negedge clk);
        cfg_we <= 1'b0;
        @(negedge clk);
    endtask

    task automatic set_config(logic [31:0] addr, logic [15:0] port);
        write_reg(REG_BIND_ADDRESS, addr);
        write_reg(REG_LISTEN_PORT, {16'($urandom_range(0, 65535)), port});
    endtask

    task automatic send_handshake(flaw_t flaw, int n_meth, bit domain, int dom_len);
        int         zero_at;
        int         noise_len;
        logic [7:0] m;
        if (flaw == FLAW_DOMLEN)
            domain = 1'b1;
        if (flaw == FLAW_NOISE)
        begin
            noise_len = int'($urandom_range(1, 4));
            repeat (noise_len) send_byte(rand_byte());
            return;
        end
        if (flaw == FLAW_GVER)
        begin
            send_byte(byte_but(SOCKS_VERSION));
            return;
        end
        send_byte(SOCKS_VERSION);
        if (flaw == FLAW_NO_METHODS)
        begin
            send_byte(8'h00);
            return;
        end
        send_byte(8'(n_meth));
        zero_at = int'($urandom_range(0, n_meth - 1));
        for (int i = 0; i < n_meth; i++)
        begin
            if (flaw == FLAW_NO_ACCEPT)
                m = byte_but(METHOD_NO_AUTH);
            else if (i == zero_at)
                m = METHOD_NO_AUTH;
            else
                m = rand_byte();
            send_byte(m);
        end
        if (flaw == FLAW_NO_ACCEPT)
            return;

        send_byte((flaw == FLAW_RVER) ? byte_but(SOCKS_VERSION) : SOCKS_VERSION);
        if (flaw == FLAW_CMD)
            send_byte(byte_but(CMD_CONNECT));
        else if (flaw == FLAW_RVER)
            send_byte(rand_byte());
        else
            send_byte(CMD_CONNECT);
        send_byte(($urandom_range(0, 1) == 0) ? RSV_BYTE : rand_byte());
        if (flaw == FLAW_ATYP)
        begin
            do
                m = rand_byte();
            while (m == ATYP_IPV4 || m == ATYP_DOMAIN);
        end
        else
            m = domain ? ATYP_DOMAIN : ATYP_IPV4;
        send_byte(m);
        if (flaw == FLAW_ATYP || flaw == FLAW_RVER || flaw == FLAW_CMD)
            return;

        if (domain)
        begin
            if (flaw == FLAW_DOMLEN)
            begin
                send_byte(($urandom_range(0, 1) == 0) ? 8'h00 : 8'hFF);
                return;
            end
            send_byte(8'(dom_len));
            repeat (dom_len) send_byte(rand_byte());
        end
        else
            repeat (4) send_byte(rand_byte());
        send_byte(rand_byte());
        send_byte(rand_byte());
    endtask

    // Mostly complete handshakes with random content, the rest broken at some stage or noise.
    task automatic random_handshake();
        flaw_t flaw;
        int    n_meth;
        if ($urandom_range(0, 99) < 60)
            flaw = FLAW_NONE;
        else
            flaw = flaw_t'($urandom_range(1, 8));
        if ($urandom_range(0, 9) == 0)
            n_meth = int'($urandom_range(7, 20));
        else
            n_meth = int'($urandom_range(1, 6));
        src_calm = ($urandom_range(0, 3) == 0);
        send_handshake(flaw, n_meth, $urandom_range(0, 1) == 1, int'($urandom_range(1, 12)));
        if ($urandom_range(0, 11) == 0)
            drain_results();
    endtask

    initial
    begin
        int stall;
        tx_ch.ready = 1'b0;
        wait (rst_n === 1'b1);
        @(negedge clk);
        forever
        begin
            if ($urandom_range(0, 15) == 0)
                sink_calm = !sink_calm;
            stall = draw_wait(sink_calm);
            if (stall > 0)
            begin
                tx_ch.ready <= 1'b0;
                repeat (stall) @(negedge clk);
            end
            tx_ch.ready <= 1'b1;
            @(posedge clk);
            while (!tx_ch.valid)
                @(posedge clk);
            @(negedge clk);
        end
    end

    initial
    begin
        int phase_start;
        rst_n = 1'b0;
        cfg_we = 1'b0;
        cfg_index = REG_BIND_ADDRESS;
        cfg_data = 32'h0;
        rx_ch.valid = 1'b0;
        rx_ch.rx_byte = 8'h00;
        directed_seq = '{
            8'hFF,
            SOCKS_VERSION, 8'h00,
            SOCKS_VERSION, 8'h01, METHOD_REJECT,
            SOCKS_VERSION, 8'h01, METHOD_NO_AUTH, SOCKS_VERSION, 8'hFF, 8'hFF, ATYP_IPV4,
            SOCKS_VERSION, 8'h01, METHOD_NO_AUTH, SOCKS_VERSION, CMD_CONNECT, 8'hFF, ATYP_IPV4,
            8'hFF, 8'h00, 8'hFF, 8'h00, 8'hFF, 8'hFF
        };
        repeat (7) @(posedge clk);
        @(negedge clk);
        rst_n <= 1'b1;
        @(negedge clk);

        // Greeting errors, a rejected command with a nonzero reserved byte, and a full IPv4
        // request, all against the register defaults.
        foreach (directed_seq[i])
            send_byte(directed_seq[i]);
        drain_results();

        for (int ph = 0; ph < 4; ph++)
        begin
            case (ph)
                0: set_config(32'hFFFF_FFFF, 16'hFFFF);
                1: set_config(32'h0000_0000, 16'h0000);
                default: set_config(32'($urandom), 16'($urandom_range(0, 65535)));
            endcase
            phase_start = bytes_sent;
            while (bytes_sent - phase_start < ITEMS_PER_PHASE)
                random_handshake();
            drain_results();
        end

        // A longer method list and domain name against the register defaults.
        set_config(BIND_ADDRESS_RESET, LISTEN_PORT_RESET);
        send_handshake(FLAW_NONE, 8, 1'b1, 12);
        drain_results();
        repeat (20) @(negedge clk);

        if (fail_count == 0 && pending_count == 0)
            $display("TB_OK");
        else
            $display("TB_ERROR");
        $finish;
    end

endmodule
